[hdl/pcas_pkg.sv]
// Shared types and constants of the Potts colouring anneal step unit.
// Used by the controller, the datapath and the top level; depends on nothing.
package pcas_pkg;

  localparam int FUNC_W     = 2;
  localparam int NODE_IN_W  = 10;
  localparam int SLOT_IN_W  = 5;
  localparam int ENTRY_W    = 10;
  localparam int COLOR_W    = 4;
  localparam int PROB_W     = 16;
  localparam int DE_OUT_W   = 6;
  localparam int BAD_W      = 15;
  localparam int MOVE_W     = 24;
  localparam int NCOL_W     = 5;
  localparam int DSUM_W     = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 24;

  localparam logic [BAD_W-1:0]  BAD_MAX          = 15'h7FFF;
  localparam logic [NCOL_W-1:0] NUM_COLORS_RST   = 5'd4;
  localparam logic [PROB_W-1:0] ACCEPT_RATIO_RST = 16'd32768;
  localparam logic [MOVE_W-1:0] MOVE_LIMIT_RST   = 24'd1000000;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_LOAD  = 2'd0,
    FUNC_START = 2'd1,
    FUNC_MOVE  = 2'd2,
    FUNC_NOP   = 2'd3
  } func_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_NUM_COLORS   = 2'd0,
    CFG_ACCEPT_RATIO = 2'd1,
    CFG_MOVE_LIMIT   = 2'd2
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_FETCH,
    ST_WALK,
    ST_POWER,
    ST_DECIDE,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic take;
    logic clear_step;
    logic fetch;
    logic walk_step;
    logic power_step;
    logic decide;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic is_start;
    logic move_ok;
    logic same_color;
    logic walk_done;
    logic power_done;
    logic clear_last;
  } status_t;

endpackage

[hdl/pcas_ctrl.sv]
// Sequencing state machine of the Potts colouring anneal step unit.
// Depends on pcas_pkg; drives pcas_datapath through cmd_t and reads status_t.
module pcas_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  pcas_pkg::status_t status,
  output pcas_pkg::cmd_t    cmd
);

  pcas_pkg::state_t state, state_next;
  logic reply_after_clear;
  logic out_free;

  assign out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state             <= pcas_pkg::ST_CLEAR;
      reply_after_clear <= 1'b0;
      out_valid         <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.take) begin
        reply_after_clear <= status.is_start;
      end
      if (cmd.emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      pcas_pkg::ST_CLEAR: begin
        if (status.clear_last) begin
          state_next = reply_after_clear ? pcas_pkg::ST_EMIT : pcas_pkg::ST_IDLE;
        end
      end
      pcas_pkg::ST_IDLE: begin
        if (in_valid) begin
          if (status.is_start) begin
            state_next = pcas_pkg::ST_CLEAR;
          end else if (status.move_ok) begin
            state_next = pcas_pkg::ST_FETCH;
          end else begin
            state_next = pcas_pkg::ST_EMIT;
          end
        end
      end
      pcas_pkg::ST_FETCH: begin
        state_next = status.same_color ? pcas_pkg::ST_DECIDE : pcas_pkg::ST_WALK;
      end
      pcas_pkg::ST_WALK: begin
        if (status.walk_done) begin
          state_next = pcas_pkg::ST_POWER;
        end
      end
      pcas_pkg::ST_POWER: begin
        if (status.power_done) begin
          state_next = pcas_pkg::ST_DECIDE;
        end
      end
      pcas_pkg::ST_DECIDE: begin
        state_next = pcas_pkg::ST_EMIT;
      end
      pcas_pkg::ST_EMIT: begin
        if (out_free) begin
          state_next = pcas_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = pcas_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    in_ready       = (state == pcas_pkg::ST_IDLE);
    cmd            = '0;
    cmd.take       = in_ready && in_valid;
    cmd.clear_step = (state == pcas_pkg::ST_CLEAR);
    cmd.fetch      = (state == pcas_pkg::ST_FETCH);
    cmd.walk_step  = (state == pcas_pkg::ST_WALK);
    cmd.power_step = (state == pcas_pkg::ST_POWER);
    cmd.decide     = (state == pcas_pkg::ST_DECIDE);
    cmd.emit       = (state == pcas_pkg::ST_EMIT) && out_free;
  end

endmodule

[hdl/pcas_datapath.sv]
// Datapath of the Potts colouring anneal step unit: tables, counters,
// neighbour walk, power unit and result register. Depends on pcas_pkg.
module pcas_datapath #(
  parameter int MAX_NODES        = 1024,
  parameter int MAX_DEGREE_SLOTS = 32,
  parameter int MAX_COLORS       = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  input  pcas_pkg::cmd_t                      cmd,
  output pcas_pkg::status_t                   status,
  input  logic [pcas_pkg::FUNC_W-1:0]         func,
  input  logic [pcas_pkg::NODE_IN_W-1:0]      node,
  input  logic [pcas_pkg::SLOT_IN_W-1:0]      slot,
  input  logic [pcas_pkg::ENTRY_W-1:0]        entry_value,
  input  logic [pcas_pkg::COLOR_W-1:0]        proposed_color,
  input  logic [pcas_pkg::PROB_W-1:0]         random_value,
  input  logic                                cfg_valid,
  input  logic [pcas_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [pcas_pkg::CFG_DATA_W-1:0]     cfg_data,
  output logic                                accepted,
  output logic signed [pcas_pkg::DE_OUT_W-1:0] energy_change,
  output logic [pcas_pkg::BAD_W-1:0]          bad_edge_count,
  output logic                                finished,
  output logic [pcas_pkg::MOVE_W-1:0]         moves_done
);

  localparam int NODE_W    = $clog2(MAX_NODES);
  localparam int SLOT_W    = $clog2(MAX_DEGREE_SLOTS);
  localparam int LIM_W     = $clog2(MAX_DEGREE_SLOTS + 1);
  localparam int DE_W      = LIM_W + 1;
  localparam int ADJ_AW    = NODE_W + SLOT_W;
  localparam int ADJ_DEPTH = 2 ** ADJ_AW;
  localparam int SUM_W     = pcas_pkg::BAD_W + 2;
  localparam int COLOR_W   = pcas_pkg::COLOR_W;
  localparam int PROB_W    = pcas_pkg::PROB_W;

  logic [pcas_pkg::NCOL_W-1:0] num_colors;
  logic [PROB_W-1:0]           accept_ratio;
  logic [pcas_pkg::MOVE_W-1:0] move_limit;

  logic [pcas_pkg::ENTRY_W-1:0] adj_mem [ADJ_DEPTH];
  logic [COLOR_W-1:0]           color_mem [MAX_NODES];
  logic [pcas_pkg::ENTRY_W-1:0] adj_rd;
  logic [COLOR_W-1:0]           color_rd;

  logic [NODE_W-1:0]           node_q;
  logic [COLOR_W-1:0]          pcol_q;
  logic [PROB_W-1:0]           rnd_q;
  logic [COLOR_W-1:0]          cur;
  logic                        same;
  logic [LIM_W-1:0]            lim;
  logic [LIM_W-1:0]            slot_ctr;
  logic                        v1, v2;
  logic [LIM_W-1:0]            old_bad, new_bad;
  logic [PROB_W-1:0]           p;
  logic signed [DE_W-1:0]      k;
  logic                        acc;
  logic [NODE_W-1:0]           clr_addr;
  logic [pcas_pkg::DSUM_W-1:0] dsum;
  logic [pcas_pkg::BAD_W-1:0]  bad;
  logic [pcas_pkg::MOVE_W-1:0] move_count;
  logic                        done;

  logic [NODE_W-1:0]           node_a;
  logic                        node_ok, slot_ok, pcol_ok, nb_ok;
  logic                        load_we, adj_re, color_re, color_we, issue;
  logic [ADJ_AW-1:0]           adj_waddr, adj_raddr;
  logic [NODE_W-1:0]           color_raddr, color_waddr;
  logic [COLOR_W-1:0]          color_wdata;
  logic [LIM_W-1:0]            lim_val;
  logic signed [DE_W-1:0]      de;
  logic [2*PROB_W-1:0]         prod;
  logic                        acc_now;
  logic signed [SUM_W-1:0]     bad_sum;
  logic [pcas_pkg::BAD_W-1:0]  bad_next;
  logic [pcas_pkg::BAD_W-1:0]  bad_start;

  assign node_a  = NODE_W'(node);
  assign node_ok = 32'(node) < MAX_NODES;
  assign slot_ok = 32'(slot) < MAX_DEGREE_SLOTS;
  assign pcol_ok = ({1'b0, proposed_color} < num_colors) && (32'(proposed_color) < MAX_COLORS);
  assign nb_ok   = 32'(adj_rd) < MAX_NODES;

  assign status.is_start   = (func == pcas_pkg::FUNC_START);
  assign status.move_ok    = (func == pcas_pkg::FUNC_MOVE) && !done && node_ok && pcol_ok;
  assign status.same_color = (color_rd == pcol_q);
  assign status.walk_done  = (slot_ctr >= lim) && !v1 && !v2;
  assign status.power_done = (de <= 0) || (k >= de);
  assign status.clear_last = (clr_addr == NODE_W'(MAX_NODES - 1));

  assign load_we   = cmd.take && (func == pcas_pkg::FUNC_LOAD) && node_ok && slot_ok;
  assign adj_waddr = {node_a, SLOT_W'(slot)};
  assign issue     = cmd.walk_step && (slot_ctr < lim);
  assign adj_re    = cmd.take || issue;
  assign adj_raddr = cmd.take ? {node_a, {SLOT_W{1'b0}}} : {node_q, SLOT_W'(slot_ctr)};

  assign color_re    = cmd.take || (cmd.walk_step && v1 && nb_ok);
  assign color_raddr = cmd.take ? node_a : NODE_W'(adj_rd);
  assign color_we    = cmd.clear_step || (cmd.decide && acc_now);
  assign color_waddr = cmd.clear_step ? clr_addr : node_q;
  assign color_wdata = cmd.clear_step ? '0 : pcol_q;

  assign lim_val = (32'(adj_rd) > MAX_DEGREE_SLOTS) ? LIM_W'(MAX_DEGREE_SLOTS)
                                                    : LIM_W'(adj_rd);
  assign de      = $signed({1'b0, new_bad}) - $signed({1'b0, old_bad});
  assign prod    = p * accept_ratio;
  assign acc_now = !same && ((de <= 0) || (p > rnd_q));
  assign bad_sum = $signed({2'b00, bad}) + SUM_W'(de);
  assign bad_start = pcas_pkg::BAD_W'(dsum >> 1);

  always_comb begin
    if (bad_sum < 0) begin
      bad_next = '0;
    end else if (bad_sum > $signed({2'b00, pcas_pkg::BAD_MAX})) begin
      bad_next = pcas_pkg::BAD_MAX;
    end else begin
      bad_next = pcas_pkg::BAD_W'(bad_sum);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      num_colors   <= pcas_pkg::NUM_COLORS_RST;
      accept_ratio <= pcas_pkg::ACCEPT_RATIO_RST;
      move_limit   <= pcas_pkg::MOVE_LIMIT_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        pcas_pkg::CFG_NUM_COLORS:   num_colors   <= cfg_data[pcas_pkg::NCOL_W-1:0];
        pcas_pkg::CFG_ACCEPT_RATIO: accept_ratio <= cfg_data[PROB_W-1:0];
        pcas_pkg::CFG_MOVE_LIMIT:   move_limit   <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (load_we) begin
      adj_mem[adj_waddr] <= entry_value;
    end
    if (adj_re) begin
      adj_rd <= adj_mem[adj_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (color_we) begin
      color_mem[color_waddr] <= color_wdata;
    end
    if (color_re) begin
      color_rd <= color_mem[color_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      node_q <= node_a;
      pcol_q <= proposed_color;
      rnd_q  <= random_value;
    end
    if (cmd.fetch) begin
      cur <= color_rd;
      same <= (color_rd == pcol_q);
      lim <= lim_val;
      p   <= accept_ratio;
      k   <= DE_W'(1);
    end else if (cmd.power_step && !status.power_done) begin
      p <= prod[2*PROB_W-1:PROB_W];
      k <= k + DE_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_ctr <= '0;
      v1       <= 1'b0;
      v2       <= 1'b0;
      old_bad  <= '0;
      new_bad  <= '0;
      acc      <= 1'b0;
      clr_addr <= '0;
      dsum     <= '0;
      bad      <= '0;
      move_count <= '0;
      done     <= 1'b0;
    end else begin
      if (cmd.clear_step) begin
        clr_addr <= status.clear_last ? '0 : clr_addr + NODE_W'(1);
      end
      if (cmd.take) begin
        old_bad <= '0;
        new_bad <= '0;
        acc     <= 1'b0;
        if (load_we && (slot == '0) && (entry_value != '0)) begin
          dsum <= dsum + pcas_pkg::DSUM_W'(entry_value) - pcas_pkg::DSUM_W'(1);
        end
        if (status.is_start) begin
          bad        <= bad_start;
          move_count <= '0;
          done       <= (bad_start == '0) || (move_limit == '0);
        end
        if (status.move_ok) begin
          move_count <= move_count + pcas_pkg::MOVE_W'(1);
        end
      end
      if (cmd.fetch) begin
        slot_ctr <= LIM_W'(1);
        v1       <= 1'b0;
        v2       <= 1'b0;
      end
      if (cmd.walk_step) begin
        if (issue) begin
          slot_ctr <= slot_ctr + LIM_W'(1);
        end
        v1 <= issue;
        v2 <= v1 && nb_ok;
        if (v2) begin
          if (color_rd == cur) begin
            old_bad <= old_bad + LIM_W'(1);
          end
          if (color_rd == pcol_q) begin
            new_bad <= new_bad + LIM_W'(1);
          end
        end
      end
      if (cmd.decide) begin
        acc <= acc_now;
        if ((acc_now && (bad_next == '0)) || (move_count >= move_limit)) begin
          done <= 1'b1;
        end
        if (acc_now) begin
          bad <= bad_next;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      accepted       <= acc;
      energy_change  <= pcas_pkg::DE_OUT_W'(de);
      bad_edge_count <= bad;
      finished       <= done;
      moves_done     <= move_count;
    end
  end

endmodule

[hdl/potts_coloring_anneal_step_unit.sv]
// Top level of the Potts colouring anneal step unit.
// Depends on pcas_pkg, pcas_ctrl and pcas_datapath.
//
// Requests enter on in_valid/in_ready (func, node, slot, entry_value,
// proposed_color, random_value); each request gives exactly one result on
// out_valid/out_ready. Registers are written on cfg_valid/cfg_ready with
// cfg_index and cfg_data; cfg_ready is always high.
// A load, an ignored move or an unused code goes straight to the result.
// A start first repaints every node, one per cycle. A move to the node's own
// colour skips the walk; any other move walks its row, where the walk reads
// one adjacency slot a cycle through a two-stage pipeline into the colour
// memory, then one 16x16 multiply per cycle raises the ratio to the power dE
// when dE is positive.
// One request is in work at a time; the next is taken once the previous
// result is in the output register, so a stalled receiver holds at most one
// result there and one request in work behind it.
// After reset the colour memory is cleared node by node, during which
// in_ready is low; the adjacency memory is not cleared and must be
// loaded before any move reads it.
module potts_coloring_anneal_step_unit #(
  parameter int MAX_NODES        = 1024,
  parameter int MAX_DEGREE_SLOTS = 32,
  parameter int MAX_COLORS       = 16
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [pcas_pkg::FUNC_W-1:0]          func,
  input  logic [pcas_pkg::NODE_IN_W-1:0]       node,
  input  logic [pcas_pkg::SLOT_IN_W-1:0]       slot,
  input  logic [pcas_pkg::ENTRY_W-1:0]         entry_value,
  input  logic [pcas_pkg::COLOR_W-1:0]         proposed_color,
  input  logic [pcas_pkg::PROB_W-1:0]          random_value,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic                                 accepted,
  output logic signed [pcas_pkg::DE_OUT_W-1:0] energy_change,
  output logic [pcas_pkg::BAD_W-1:0]           bad_edge_count,
  output logic                                 finished,
  output logic [pcas_pkg::MOVE_W-1:0]          moves_done,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [pcas_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [pcas_pkg::CFG_DATA_W-1:0]      cfg_data
);

  pcas_pkg::cmd_t    cmd;
  pcas_pkg::status_t status;

  assign cfg_ready = 1'b1;

  pcas_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  pcas_datapath #(
    .MAX_NODES        (MAX_NODES),
    .MAX_DEGREE_SLOTS (MAX_DEGREE_SLOTS),
    .MAX_COLORS       (MAX_COLORS)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .status         (status),
    .func           (func),
    .node           (node),
    .slot           (slot),
    .entry_value    (entry_value),
    .proposed_color (proposed_color),
    .random_value   (random_value),
    .cfg_valid      (cfg_valid && cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .accepted       (accepted),
    .energy_change  (energy_change),
    .bad_edge_count (bad_edge_count),
    .finished       (finished),
    .moves_done     (moves_done)
  );

endmodule

[hdl/pcas_checker.sv]
// Port-level checks of the Potts colouring anneal step unit, bound to the top.
// Depends on pcas_pkg.
module pcas_checker (
  input logic                                 clk,
  input logic                                 rst,
  input logic                                 in_valid,
  input logic                                 in_ready,
  input logic                                 out_valid,
  input logic                                 out_ready,
  input logic                                 accepted,
  input logic signed [pcas_pkg::DE_OUT_W-1:0] energy_change,
  input logic [pcas_pkg::BAD_W-1:0]           bad_edge_count,
  input logic                                 finished,
  input logic [pcas_pkg::MOVE_W-1:0]          moves_done
);

  a_one_in_work: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("request taken while another is in work");

  a_result_held: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(accepted) && $stable(energy_change)
      && $stable(bad_edge_count) && $stable(finished) && $stable(moves_done))
    else $error("stalled result changed");

  a_solved_finishes: assert property (@(posedge clk) disable iff (rst)
    out_valid && accepted && (bad_edge_count == '0) |-> finished)
    else $error("accepted move reached zero bad edges without finishing");

  a_accept_counted: assert property (@(posedge clk) disable iff (rst)
    out_valid && accepted |-> moves_done != '0)
    else $error("accepted move not counted");

endmodule

bind potts_coloring_anneal_step_unit pcas_checker u_chk (.*);

[tb/potts_coloring_anneal_step_unit_test.sv]
// Regression bench for potts_coloring_anneal_step_unit: directed table, then random phases.
// Results are checked against the table's expected values or an in-bench predictor of the annealing step.
// Depends on pcas_pkg and the RTL of the unit.
module potts_coloring_anneal_step_unit_test;

  localparam int NODES = 1024;
  localparam int SLOTS = 32;
  localparam int GRAPH_NODES = 48;
  localparam int CYCLE_LIMIT = 10000000;

  typedef struct packed {
    logic        acc;
    logic [5:0]  de;
    logic [14:0] bad;
    logic        fin;
    logic [23:0] moves;
  } step_result_t;

  typedef struct {
    pcas_pkg::func_t f;
    logic [9:0]   n;
    logic [4:0]   s;
    logic [9:0]   e;
    logic [3:0]   c;
    logic [15:0]  r;
    bit           typed;
    step_result_t x;
  } stim_row_t;

  logic clk;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [pcas_pkg::FUNC_W-1:0] func = pcas_pkg::FUNC_NOP;
  logic [pcas_pkg::NODE_IN_W-1:0] node = '0;
  logic [pcas_pkg::SLOT_IN_W-1:0] slot = '0;
  logic [pcas_pkg::ENTRY_W-1:0] entry_value = '0;
  logic [pcas_pkg::COLOR_W-1:0] proposed_color = '0;
  logic [pcas_pkg::PROB_W-1:0] random_value = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic accepted;
  logic signed [pcas_pkg::DE_OUT_W-1:0] energy_change;
  logic [pcas_pkg::BAD_W-1:0] bad_edge_count;
  logic finished;
  logic [pcas_pkg::MOVE_W-1:0] moves_done;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [pcas_pkg::CFG_IDX_W-1:0] cfg_index = pcas_pkg::CFG_NUM_COLORS;
  logic [pcas_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  potts_coloring_anneal_step_unit dut (.*);

  logic [3:0] colour_mem [NODES];
  logic [9:0] adj_mem [NODES*SLOTS];
  bit adj_written [NODES*SLOTS];
  logic [15:0] degree_total;
  int bad_total;
  logic [23:0] move_total;
  bit run_done;
  logic [4:0] ncolours;
  logic [15:0] ratio;
  logic [23:0] limit;

  step_result_t expected_results[$];
  stim_row_t directed_rows[$];
  int mismatches = 0;
  int items_sent = 0;
  int moves_taken = 0;
  int starts_sent = 0;
  int results_seen = 0;
  bit quiet = 0;
  bit hold_req = 0;
  longint cycles = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("potts_coloring_anneal_step_unit regression: fail");
      $finish;
    end
  end

  function automatic step_result_t predict_anneal(pcas_pkg::func_t f, logic [9:0] n,
                                                  logic [4:0] s, logic [9:0] e,
                                                  logic [3:0] c, logic [15:0] r);
    step_result_t res;
    int lim, old_bad, new_bad, de;
    logic [3:0] cur;
    logic [9:0] nb;
    longint p;
    bit acc;
    acc = 0;
    de = 0;
    if (f == pcas_pkg::FUNC_LOAD) begin
      adj_mem[n*SLOTS+s] = e;
      adj_written[n*SLOTS+s] = 1;
      if (s == 0 && e > 0) degree_total = degree_total + 16'(e - 1);
    end else if (f == pcas_pkg::FUNC_START) begin
      foreach (colour_mem[i]) colour_mem[i] = '0;
      bad_total = int'(degree_total >> 1);
      move_total = '0;
      run_done = (bad_total == 0) || (limit == 0);
    end else if (f == pcas_pkg::FUNC_MOVE && !run_done && c < ncolours) begin
      move_total = move_total + 24'(1);
      cur = colour_mem[n];
      if (cur != c) begin
        lim = int'(adj_mem[n*SLOTS]);
        if (lim > SLOTS) lim = SLOTS;
        old_bad = 0;
        new_bad = 0;
        for (int i = 1; i < lim; i++) begin
          nb = adj_mem[n*SLOTS+i];
          if (colour_mem[nb] == cur) old_bad++;
          if (colour_mem[nb] == c) new_bad++;
        end
        de = new_bad - old_bad;
        if (de <= 0) acc = 1;
        else begin
          p = longint'(ratio);
          for (int k = 1; k < de; k++) p = (p * ratio) >> 16;
          acc = p > r;
        end
        if (acc) begin
          colour_mem[n] = c;
          bad_total += de;
          if (bad_total < 0) bad_total = 0;
          if (bad_total > 32767) bad_total = 32767;
          if (bad_total == 0) run_done = 1;
        end
      end
      if (move_total >= limit) run_done = 1;
    end
    res.acc = acc;
    res.de = 6'(de);
    res.bad = 15'(bad_total);
    res.fin = run_done;
    res.moves = move_total;
    return res;
  endfunction

  function automatic bit row_ready(logic [9:0] n);
    int lim;
    if (!adj_written[n*SLOTS]) return 0;
    lim = int'(adj_mem[n*SLOTS]);
    if (lim > SLOTS) lim = SLOTS;
    for (int i = 1; i < lim; i++)
      if (!adj_written[n*SLOTS+i]) return 0;
    return 1;
  endfunction

  function automatic bit move_reads(logic [9:0] n, logic [3:0] c);
    return !run_done && c < ncolours && colour_mem[n] != c;
  endfunction

  function automatic stim_row_t mk(pcas_pkg::func_t f, int n, int s, int e, int c, int r,
                                   bit typed, int acc, int de, int bad, int fin, int mv);
    stim_row_t row;
    row.f = f;
    row.n = 10'(n);
    row.s = 5'(s);
    row.e = 10'(e);
    row.c = 4'(c);
    row.r = 16'(r);
    row.typed = typed;
    row.x.acc = 1'(acc);
    row.x.de = 6'(de);
    row.x.bad = 15'(bad);
    row.x.fin = 1'(fin);
    row.x.moves = 24'(mv);
    return row;
  endfunction

  task automatic send_request(stim_row_t row);
    int gap;
    step_result_t pred;
    gap = quiet ? 0 : $urandom_range(0, 14);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    func <= row.f;
    node <= row.n;
    slot <= row.s;
    entry_value <= row.e;
    proposed_color <= row.c;
    random_value <= row.r;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pred = predict_anneal(row.f, row.n, row.s, row.e, row.c, row.r);
    expected_results.push_back(row.typed ? row.x : pred);
    items_sent++;
    if (row.f == pcas_pkg::FUNC_START) starts_sent++;
    if (pred.acc) moves_taken++;
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
  endtask

  task automatic program_regs(int nc, int ar, int ml);
    int vals[3];
    vals = '{nc, ar, ml};
    for (int i = 0; i < 3; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= pcas_pkg::CFG_IDX_W'(i);
      cfg_data <= pcas_pkg::CFG_DATA_W'(vals[i]);
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
    end
    cfg_valid <= 1'b0;
    ncolours = 5'(nc);
    ratio = 16'(ar);
    limit = 24'(ml);
  endtask

  task automatic random_request();
    stim_row_t row;
    int pick, tries;
    row = mk(pcas_pkg::FUNC_NOP, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    pick = $urandom_range(0, 99);
    row.n = 10'($urandom_range(0, 1023));
    row.s = 5'($urandom_range(0, 31));
    row.e = 10'($urandom_range(0, 1023));
    row.c = 4'($urandom_range(0, 15));
    row.r = 16'($urandom_range(0, 65535));
    if (pick < 70) begin
      row.f = pcas_pkg::FUNC_MOVE;
      if ($urandom_range(0, 9) != 0) row.n = 10'($urandom_range(0, GRAPH_NODES - 1));
      if ($urandom_range(0, 9) == 0) row.r = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
      tries = 0;
      while (move_reads(row.n, row.c) && !row_ready(row.n) && tries < 16) begin
        row.n = 10'($urandom_range(0, GRAPH_NODES - 1));
        tries++;
      end
      if (move_reads(row.n, row.c) && !row_ready(row.n)) row.c = colour_mem[row.n];
    end else if (pick < 85) begin
      row.f = pcas_pkg::FUNC_LOAD;
      row.n = 10'($urandom_range(0, GRAPH_NODES - 1));
      if ($urandom_range(0, 9) == 0) begin
        row.s = '0;
        row.e = 10'($urandom_range(1, 6));
      end else begin
        row.s = 5'($urandom_range(1, 5));
        row.e = 10'($urandom_range(0, GRAPH_NODES - 1));
      end
    end else if (pick < 92) begin
      row.f = pcas_pkg::FUNC_LOAD;
    end else if (pick < 96) begin
      row.f = pcas_pkg::FUNC_NOP;
    end else begin
      row.f = pcas_pkg::FUNC_START;
    end
    send_request(row);
  endtask

  initial begin
    int hold;
    forever begin
      hold = quiet ? 0 : $urandom_range(0, 14);
      if (hold_req) begin
        hold = 400;
        hold_req = 0;
      end
      if (hold > 0) begin
        out_ready <= 1'b0;
        repeat (hold) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      results_seen++;
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result at cycle %0d", cycles);
      end else begin
        step_result_t want;
        want = expected_results.pop_front();
        if (want.acc !== accepted || want.de !== $unsigned(energy_change) ||
            want.bad !== bad_edge_count || want.fin !== finished ||
            want.moves !== moves_done) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch %0d: expected acc %0d de %0d bad %0d fin %0d moves %0d, got %0d %0d %0d %0d %0d",
                     results_seen, want.acc, $signed(want.de), want.bad, want.fin, want.moves,
                     accepted, energy_change, bad_edge_count, finished, moves_done);
        end
      end
    end
  end

  initial begin
    int nc, ar, ml, deg;
    foreach (colour_mem[i]) colour_mem[i] = '0;
    foreach (adj_mem[i]) adj_mem[i] = '0;
    foreach (adj_written[i]) adj_written[i] = 0;
    degree_total = '0;
    bad_total = 0;
    move_total = '0;
    run_done = 0;
    ncolours = pcas_pkg::NUM_COLORS_RST;
    ratio = pcas_pkg::ACCEPT_RATIO_RST;
    limit = pcas_pkg::MOVE_LIMIT_RST;

    directed_rows.push_back(mk(pcas_pkg::FUNC_NOP, 0, 0, 0, 0, 0, 1, 0, 0, 0, 0, 0));
    directed_rows.push_back(mk(pcas_pkg::FUNC_MOVE, 5, 0, 0, 7, 0, 1, 0, 0, 0, 0, 0));
    directed_rows.push_back(mk(pcas_pkg::FUNC_LOAD, 1023, 31, 1023, 0, 0, 1, 0, 0, 0, 0, 0));
    directed_rows.push_back(mk(pcas_pkg::FUNC_LOAD, 0, 0, 0, 0, 0, 1, 0, 0, 0, 0, 0));
    directed_rows.push_back(mk(pcas_pkg::FUNC_START, 0, 0, 0, 0, 0, 1, 0, 0, 0, 1, 0));
    directed_rows.push_back(mk(pcas_pkg::FUNC_LOAD, 1, 0, 3, 0, 0, 1, 0, 0, 0, 1, 0));
    directed_rows.push_back(mk(pcas_pkg::FUNC_LOAD, 1, 1, 2, 0, 0, 1, 0, 0, 0, 1, 0));
    directed_rows.push_back(mk(pcas_pkg::FUNC_LOAD, 1, 2, 3, 0, 0, 1, 0, 0, 0, 1, 0));
    directed_rows.push_back(mk(pcas_pkg::FUNC_LOAD, 2, 0, 2, 0, 0, 1, 0, 0, 0, 1, 0));
    directed_rows.push_back(mk(pcas_pkg::FUNC_LOAD, 2, 1, 1, 0, 0, 1, 0, 0, 0, 1, 0));
    directed_rows.push_back(mk(pcas_pkg::FUNC_LOAD, 3, 0, 2, 0, 0, 1, 0, 0, 0, 1, 0));
    directed_rows.push_back(mk(pcas_pkg::FUNC_LOAD, 3, 1, 1, 0, 0, 1, 0, 0, 0, 1, 0));
    directed_rows.push_back(mk(pcas_pkg::FUNC_START, 0, 0, 0, 0, 0, 1, 0, 0, 2, 0, 0));
    directed_rows.push_back(mk(pcas_pkg::FUNC_MOVE, 1, 0, 0, 1, 0, 1, 1, -2, 0, 1, 1));
    directed_rows.push_back(mk(pcas_pkg::FUNC_MOVE, 2, 0, 0, 1, 0, 1, 0, 0, 0, 1, 1));
    directed_rows.push_back(mk(pcas_pkg::FUNC_START, 0, 0, 0, 0, 0, 1, 0, 0, 2, 0, 0));
    directed_rows.push_back(mk(pcas_pkg::FUNC_MOVE, 2, 0, 0, 0, 0, 1, 0, 0, 2, 0, 1));
    directed_rows.push_back(mk(pcas_pkg::FUNC_MOVE, 2, 0, 0, 1, 0, 1, 1, -1, 1, 0, 2));
    directed_rows.push_back(mk(pcas_pkg::FUNC_MOVE, 2, 0, 0, 0, 65535, 1, 0, 1, 1, 0, 3));
    directed_rows.push_back(mk(pcas_pkg::FUNC_MOVE, 2, 0, 0, 0, 0, 1, 1, 1, 2, 0, 4));
    directed_rows.push_back(mk(pcas_pkg::FUNC_MOVE, 3, 0, 0, 4, 0, 1, 0, 0, 2, 0, 4));
    directed_rows.push_back(mk(pcas_pkg::FUNC_MOVE, 3, 0, 0, 15, 0, 1, 0, 0, 2, 0, 4));
    directed_rows.push_back(mk(pcas_pkg::FUNC_NOP, 1023, 31, 1023, 15, 65535, 1, 0, 0, 2, 0, 4));
    directed_rows.push_back(mk(pcas_pkg::FUNC_MOVE, 2, 0, 0, 3, 65535, 1, 1, -1, 1, 0, 5));
    directed_rows.push_back(mk(pcas_pkg::FUNC_MOVE, 3, 0, 0, 2, 0, 0, 0, 0, 0, 0, 0));

    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_rows[i]) send_request(directed_rows[i]);
    drain_results();

    for (int g = 4; g < GRAPH_NODES; g++) begin
      deg = $urandom_range(1, 5);
      send_request(mk(pcas_pkg::FUNC_LOAD, g, 0, deg + 1, 0, 0, 0, 0, 0, 0, 0, 0));
      for (int k = 1; k <= 5; k++)
        send_request(mk(pcas_pkg::FUNC_LOAD, g, k, $urandom_range(0, GRAPH_NODES - 1),
                        0, 0, 0, 0, 0, 0, 0, 0));
    end
    for (int g = 0; g < 4; g++)
      for (int k = 1; k <= 5; k++)
        send_request(mk(pcas_pkg::FUNC_LOAD, g, k, $urandom_range(0, GRAPH_NODES - 1),
                        0, 0, 0, 0, 0, 0, 0, 0));

    for (int phase = 0; phase < 12; phase++) begin
      drain_results();
      nc = $urandom_range(1, 16);
      ar = $urandom_range(0, 65535);
      ml = $urandom_range(20, 200);
      case (phase)
        0: begin nc = 16; ar = 65535; ml = 16777215; end
        1: begin nc = 1; ar = 0; ml = 1000000; end
        2: ml = 0;
        3: ar = 65535;
        5: begin nc = 16; ar = 0; end
        default: ;
      endcase
      program_regs(nc, ar, ml);
      quiet = (phase == 4) || (phase == 9);
      if (phase == 3) hold_req = 1;
      send_request(mk(pcas_pkg::FUNC_START, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
      repeat (phase == 2 ? 30 : 100) random_request();
    end
    quiet = 0;
    drain_results();
    repeat (1100) @(posedge clk);

    $display("covered %0d requests in 12 register settings: %0d starts, %0d moves applied",
             items_sent, starts_sent, moves_taken);
    $display("%0d results compared, %0d mismatches", results_seen, mismatches);
    if (mismatches == 0 && expected_results.size() == 0)
      $display("potts_coloring_anneal_step_unit regression: pass");
    else
      $display("potts_coloring_anneal_step_unit regression: fail");
    $finish;
  end

endmodule
